/* rtl/sakv_pkg.sv */
// Shared types, constants and codes for the sorted key/value aggregation table.
package sakv_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 64;
	localparam int ENTRY_W     = KEY_W + VAL_W;
	localparam int USED_W      = 9;
	localparam int GROUP_SIZE  = 16;
	localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_DEPTH   = NUM_GROUPS * GROUP_SIZE;

	localparam logic [1:0] OP_ACCUM = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] MODE_SUM   = 2'd0;
	localparam logic [1:0] MODE_FLOOR = 2'd1;
	localparam logic [1:0] MODE_MIN   = 2'd2;
	localparam logic [1:0] MODE_MAX   = 2'd3;

	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_FLOOR = 3'd1;
	localparam logic [2:0] STAT_OVF   = 3'd2;
	localparam logic [2:0] STAT_FULL  = 3'd3;
	localparam logic [2:0] STAT_RANGE = 3'd4;

	localparam logic [1:0] REG_AGG_MODE = 2'd0;
	localparam logic [1:0] REG_FLOOR    = 2'd1;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [KEY_W-1:0] pair_key;
		logic signed [VAL_W-1:0] pair_value;
		logic [7:0]              read_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]              status;
		logic signed [KEY_W-1:0] entry_key;
		logic signed [VAL_W-1:0] entry_value;
		logic [USED_W-1:0]       entries_used;
	} out_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                    cmp_en;
		logic                    is_read;
		logic                    upd_en;
		logic                    ins_en;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] new_value;
	} cell_ctrl_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CMP   = 6'b000010,
		S_RED1  = 6'b000100,
		S_RED2  = 6'b001000,
		S_EXEC  = 6'b010000,
		S_APPLY = 6'b100000
	} state_t;

endpackage

/* rtl/sakv_cell.sv */
// One table cell: holds one entry, compares it with the broadcast key and shifts on insert.
module sakv_cell
	import sakv_pkg::*;
(
	input  logic       clk,
	input  logic       occupied,
	input  logic       read_sel,
	input  cell_ctrl_t ctrl,
	input  logic       prev_lt,
	input  entry_t     prev_ent,
	output logic       lt,
	output logic       hit,
	output entry_t     ent
);

	entry_t ent_q;
	logic   lt_q;
	logic   hit_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_q  <= occupied && (ent_q.key < ctrl.key);
			hit_q <= occupied && (ctrl.is_read ? read_sel : (ent_q.key == ctrl.key));
		end
		if (ctrl.upd_en && hit_q) begin
			ent_q.value <= ctrl.new_value;
		end else if (ctrl.ins_en && !lt_q) begin
			// The first cell not below the new key takes the pair; the rest move up by one.
			if (prev_lt) begin
				ent_q.key   <= ctrl.key;
				ent_q.value <= ctrl.value;
			end else begin
				ent_q <= prev_ent;
			end
		end
	end

	assign lt  = lt_q;
	assign hit = hit_q;
	assign ent = ent_q;

endmodule

/* rtl/sakv_match_tree.sv */
// Two-stage registered OR tree that pulls the single hit entry out of the cell row.
module sakv_match_tree
	import sakv_pkg::*;
(
	input  logic   clk,
	input  logic   hit [TABLE_DEPTH],
	input  entry_t ents [TABLE_DEPTH],
	output logic   found,
	output entry_t match_ent
);

	logic [ENTRY_W-1:0] masked [PAD_DEPTH];
	logic               pad_hit [PAD_DEPTH];
	logic [ENTRY_W-1:0] grp_ent_s1 [NUM_GROUPS];
	logic               grp_hit_s1 [NUM_GROUPS];
	logic [ENTRY_W-1:0] ent_s2;
	logic               hit_s2;

	for (genvar i = 0; i < PAD_DEPTH; i++) begin : g_mask
		if (i < TABLE_DEPTH) begin : g_real
			assign masked[i]  = hit[i] ? ENTRY_W'(ents[i]) : '0;
			assign pad_hit[i] = hit[i];
		end else begin : g_pad
			assign masked[i]  = '0;
			assign pad_hit[i] = 1'b0;
		end
	end

	// At most one cell hits, so OR-ing the masked entries selects it.
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		logic [ENTRY_W-1:0] acc_e;
		logic               acc_h;
		always_comb begin
			acc_e = '0;
			acc_h = 1'b0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				acc_e = acc_e | masked[g * GROUP_SIZE + j];
				acc_h = acc_h | pad_hit[g * GROUP_SIZE + j];
			end
		end
		always_ff @(posedge clk) begin
			grp_ent_s1[g] <= acc_e;
			grp_hit_s1[g] <= acc_h;
		end
	end

	logic [ENTRY_W-1:0] top_e;
	logic               top_h;

	always_comb begin
		top_e = '0;
		top_h = 1'b0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			top_e = top_e | grp_ent_s1[g];
			top_h = top_h | grp_hit_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		ent_s2 <= top_e;
		hit_s2 <= top_h;
	end

	assign found     = hit_s2;
	assign match_ent = entry_t'(ent_s2);

endmodule

/* rtl/sorted_key_value_aggregator_core.sv */
// Top level of the sorted key/value aggregation table: sequencer, cell row and output register.
// After the edge that accepts a transaction, the sequencer steps through S_CMP (all cells compare in
// parallel), S_RED1 and S_RED2 (the registered match tree), S_EXEC (combine) and S_APPLY (write
// the cells and load the output register). A new transaction is taken only in the cycle after the
// write-back, so the core holds one transaction at a time; a result still waiting in the output
// register holds the write-back, and so the input, until taken.
// Reset (arst_n low) empties the table, returns agg_mode and floor_value to zero, drops any result.
module sorted_key_value_aggregator_core
	import sakv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_item,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [VAL_W-1:0]    cfg_data
);

	// Configuration registers.
	logic [1:0]              agg_mode_q;
	logic signed [VAL_W-1:0] floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agg_mode_q <= MODE_SUM;
			floor_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_AGG_MODE: agg_mode_q <= cfg_data[1:0];
				REG_FLOOR:    floor_q    <= $signed(cfg_data);
				default:      ;
			endcase
		end
	end

	// Sequencer state, the captured transaction and the entry count.
	state_t            state_q;
	in_item_t          cmd_q;
	logic [CNT_W-1:0]  count_q;
	logic              apply_fire;

	// Decision registered in the combine cycle and applied in the write-back cycle.
	out_item_t               res_q;
	logic                    upd_q;
	logic                    ins_q;
	logic signed [VAL_W-1:0] new_val_q;
	logic [CNT_W-1:0]        next_cnt_q;

	logic                    out_valid_q;
	out_item_t               out_q;

	assign in_ready   = (state_q == S_IDLE);
	assign apply_fire = (state_q == S_APPLY) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_CMP;
				S_CMP:   state_q <= S_RED1;
				S_RED1:  state_q <= S_RED2;
				S_RED2:  state_q <= S_EXEC;
				S_EXEC:  state_q <= S_APPLY;
				S_APPLY: if (apply_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_item;
		end
	end

	// Cell row. Each cell sees its left neighbor's entry and "below key" flag, so an insert
	// shifts every cell at or above the insertion point together, in the write-back.
	cell_ctrl_t ctrl;
	logic       cell_lt  [TABLE_DEPTH];
	logic       cell_hit [TABLE_DEPTH];
	entry_t     cell_ent [TABLE_DEPTH];

	assign ctrl.cmp_en    = (state_q == S_CMP);
	assign ctrl.is_read   = (cmd_q.operation == OP_READ);
	assign ctrl.upd_en    = apply_fire && upd_q;
	assign ctrl.ins_en    = apply_fire && ins_q;
	assign ctrl.key       = cmd_q.pair_key;
	assign ctrl.value     = cmd_q.pair_value;
	assign ctrl.new_value = new_val_q;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic   occ;
		logic   rsel;
		logic   p_lt;
		entry_t p_ent;

		assign occ  = (32'(i) < 32'(count_q));
		assign rsel = (32'(i) == 32'(cmd_q.read_index));

		if (i == 0) begin : g_first
			assign p_lt  = 1'b1;
			assign p_ent = '0;
		end else begin : g_next
			assign p_lt  = cell_lt[i-1];
			assign p_ent = cell_ent[i-1];
		end

		sakv_cell u_cell (
			.clk      (clk),
			.occupied (occ),
			.read_sel (rsel),
			.ctrl     (ctrl),
			.prev_lt  (p_lt),
			.prev_ent (p_ent),
			.lt       (cell_lt[i]),
			.hit      (cell_hit[i]),
			.ent      (cell_ent[i])
		);
	end

	// The registered match tree delivers the hit entry from the compare results.
	logic   found;
	entry_t match_ent;

	sakv_match_tree u_tree (
		.clk       (clk),
		.hit       (cell_hit),
		.ents      (cell_ent),
		.found     (found),
		.match_ent (match_ent)
	);

	// Combine cycle: the stored value is known, so the rule, the floor test and the
	// overflow check are worked out here and registered for the write-back.
	out_item_t               res_d;
	logic                    upd_d;
	logic                    ins_d;
	logic signed [VAL_W-1:0] new_val_d;
	logic [CNT_W-1:0]        next_cnt_d;
	logic signed [VAL_W-1:0] old_val;
	logic signed [VAL_W-1:0] sum;
	logic                    below;
	logic                    ovf;

	always_comb begin
		old_val    = match_ent.value;
		sum        = old_val + cmd_q.pair_value;
		ovf        = (old_val[VAL_W-1] == cmd_q.pair_value[VAL_W-1]) &&
		             (sum[VAL_W-1] != old_val[VAL_W-1]);
		below      = (agg_mode_q == MODE_FLOOR) && (cmd_q.pair_value < floor_q);
		res_d      = '0;
		res_d.status = STAT_OK;
		upd_d      = 1'b0;
		ins_d      = 1'b0;
		new_val_d  = old_val;
		next_cnt_d = count_q;

		case (cmd_q.operation)
			OP_ACCUM: begin
				res_d.entry_key = cmd_q.pair_key;
				if (below) begin
					res_d.status      = STAT_FLOOR;
					res_d.entry_value = found ? old_val : '0;
				end else if (found) begin
					case (agg_mode_q) inside
						MODE_SUM, MODE_FLOOR: new_val_d = sum;
						MODE_MIN: new_val_d = (cmd_q.pair_value < old_val) ?
						                      cmd_q.pair_value : old_val;
						default:  new_val_d = (old_val < cmd_q.pair_value) ?
						                      cmd_q.pair_value : old_val;
					endcase
					if ((agg_mode_q == MODE_SUM || agg_mode_q == MODE_FLOOR) && ovf) begin
						res_d.status      = STAT_OVF;
						res_d.entry_value = old_val;
					end else begin
						upd_d             = 1'b1;
						res_d.entry_value = new_val_d;
					end
				end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
					res_d.status = STAT_FULL;
				end else begin
					ins_d             = 1'b1;
					res_d.entry_value = cmd_q.pair_value;
					next_cnt_d        = count_q + 1'b1;
				end
			end
			OP_READ: begin
				if (found) begin
					res_d.entry_key   = match_ent.key;
					res_d.entry_value = match_ent.value;
				end else begin
					res_d.status = STAT_RANGE;
				end
			end
			OP_CLEAR: begin
				next_cnt_d = '0;
			end
			default: ;
		endcase
		res_d.entries_used = USED_W'(next_cnt_d);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			res_q      <= res_d;
			new_val_q  <= new_val_d;
			next_cnt_q <= next_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q <= 1'b0;
			ins_q <= 1'b0;
		end else if (state_q == S_EXEC) begin
			upd_q <= upd_d;
			ins_q <= ins_d;
		end
	end

	// Entry count and output register; the write-back waits while an earlier result still
	// sits untaken in the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply_fire) begin
				count_q     <= next_cnt_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= TABLE_DEPTH)
		else $error("entry count beyond table depth");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CMP))
		else $error("accepted transaction did not start the compare");

	a_upd_ins_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> !(upd_q && ins_q))
		else $error("update and insert requested together");

	a_count_only_on_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(apply_fire))
		else $error("entry count changed outside write-back");

	a_out_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(apply_fire))
		else $error("result appeared without write-back");
`endif

endmodule
